/* rtl/pair_id_intern_table_unit_defines.svh */
// ---------------------------------------------------------------------------
// pair_id_intern_table_unit assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and held off
// while the asynchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef PAIR_ID_INTERN_TABLE_UNIT_DEFINES_SVH
`define PAIR_ID_INTERN_TABLE_UNIT_DEFINES_SVH

// Check a property in every cycle outside reset.
`define PIDIT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define PIDIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/pidit_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pidit_pkg
// Request codes, field widths and the structs passed along the cell row.
// ---------------------------------------------------------------------------
package pidit_pkg;

	localparam int KIND_W = 3;
	localparam int NODE_W = 16;
	localparam int KEY_W  = 2 * NODE_W;
	localparam int RES_W  = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR      = 3'd0,
		KIND_SEED_CONN  = 3'd1,
		KIND_SEED_NODE  = 3'd2,
		KIND_CONN_ID    = 3'd3,
		KIND_FRESH_NODE = 3'd4,
		KIND_SPLIT_ID   = 3'd5
	} kind_e;

	// Token walking the cell row
	typedef struct packed {
		logic live;
		logic done;
		logic hit;
	} tok_t;

	// Request context broadcast to every cell
	typedef struct packed {
		logic             clr;
		logic             split;
		logic             seed;
		logic [KEY_W-1:0] key;
	} bcast_t;

endpackage

/* rtl/pidit_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pidit_if
// Valid/ready channels for requests and results of the pair intern table.
// ---------------------------------------------------------------------------
interface pidit_req_if;
	import pidit_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [NODE_W-1:0] from_node;
	logic [NODE_W-1:0] to_node;
	logic [NODE_W-1:0] given_id;

	modport source (output valid, kind, from_node, to_node, given_id, input ready);
	modport sink (input valid, kind, from_node, to_node, given_id, output ready);
endinterface

interface pidit_rsp_if;
	import pidit_pkg::*;

	logic             valid;
	logic             ready;
	logic [RES_W-1:0] result_id;
	logic             was_found;
	logic             table_full;
	logic             counter_overflow;

	modport source (output valid, result_id, was_found, table_full, counter_overflow,
		input ready);
	modport sink (input valid, result_id, was_found, table_full, counter_overflow,
		output ready);
endinterface

/* rtl/pidit_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pidit_cell
// One entry of the connection table and one of the split table. Compares the
// broadcast key, writes the first free entry or a seed hit, passes the token.
// ---------------------------------------------------------------------------
`include "pair_id_intern_table_unit_defines.svh"

module pidit_cell #(
	parameter int ID_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pidit_pkg::bcast_t     bc,
	input  logic [ID_BITS-1:0]    wr_id,
	input  pidit_pkg::tok_t       tin,
	input  logic [ID_BITS-1:0]    tin_id,
	output pidit_pkg::tok_t       tout,
	output logic [ID_BITS-1:0]    tout_id
);
	import pidit_pkg::*;

	logic [KEY_W-1:0]   conn_key_q;
	logic [KEY_W-1:0]   split_key_q;
	logic [ID_BITS-1:0] conn_id_q;
	logic [ID_BITS-1:0] split_id_q;
	logic               conn_v_q;
	logic               split_v_q;
	tok_t               tok_q;
	logic [ID_BITS-1:0] tok_id_q;

	logic               ent_v;
	logic               ent_hit;
	logic [ID_BITS-1:0] ent_id;
	logic               probe;
	logic               do_ins;
	logic               do_ovw;

	assign ent_v   = bc.split ? split_v_q : conn_v_q;
	assign ent_hit = ent_v && ((bc.split ? split_key_q : conn_key_q) == bc.key);
	assign ent_id  = bc.split ? split_id_q : conn_id_q;
	assign probe   = tin.live && !tin.done;
	// Entries fill from the front, so the first free entry ends the search
	assign do_ins  = probe && !ent_v;
	assign do_ovw  = probe && ent_hit && bc.seed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conn_v_q  <= 1'b0;
			split_v_q <= 1'b0;
			tok_q     <= '0;
		end else begin
			if (bc.clr) begin
				conn_v_q  <= 1'b0;
				split_v_q <= 1'b0;
			end else if (do_ins) begin
				if (bc.split) begin
					split_v_q <= 1'b1;
				end else begin
					conn_v_q <= 1'b1;
				end
			end
			tok_q.live <= tin.live;
			tok_q.done <= tin.done || (probe && (ent_hit || !ent_v));
			tok_q.hit  <= tin.hit || (probe && ent_hit);
		end
	end

	always_ff @(posedge clk) begin
		if (do_ins || do_ovw) begin
			if (bc.split) begin
				split_key_q <= bc.key;
				split_id_q  <= wr_id;
			end else begin
				conn_key_q <= bc.key;
				conn_id_q  <= wr_id;
			end
		end
		tok_id_q <= (probe && ent_hit) ? ent_id : tin_id;
	end

	assign tout    = tok_q;
	assign tout_id = tok_id_q;

	`PIDIT_ASSERT_NEXT(a_done_sticky, clk, arst_n, tin.live && tin.done, tout.live && tout.done, "resolved token lost its result")
	`PIDIT_ASSERT_NEXT(a_hit_sticky, clk, arst_n, tin.live && tin.hit, tout.hit && tout.done, "hit flag dropped along the row")
	`PIDIT_ASSERT_NEXT(a_conn_insert, clk, arst_n, do_ins && !bc.split && !bc.clr, conn_v_q, "connection insert did not mark entry valid")

endmodule

/* rtl/pidit_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pidit_ctrl
// Request sequencer: holds both counters, launches the search token, and
// forms each result, for table searches from the token leaving the row.
// ---------------------------------------------------------------------------
`include "pair_id_intern_table_unit_defines.svh"

module pidit_ctrl #(
	parameter int ID_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	pidit_req_if.sink          req,
	pidit_rsp_if.source        rsp,
	output pidit_pkg::bcast_t  bc,
	output logic [ID_BITS-1:0] wr_id,
	output pidit_pkg::tok_t    launch,
	input  pidit_pkg::tok_t    tail,
	input  logic [ID_BITS-1:0] tail_id
);
	import pidit_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	localparam logic [ID_BITS-1:0] ID_MAX = '1;

	state_t             state_q;
	logic [KIND_W-1:0]  kind_q;
	logic [KEY_W-1:0]   key_q;
	logic [ID_BITS-1:0] g_q;
	logic [ID_BITS-1:0] wr_id_q;
	logic               split_q;
	logic               seed_q;
	logic               clr_q;
	logic               launch_q;
	logic [ID_BITS-1:0] conn_ctr_q;
	logic [ID_BITS-1:0] node_ctr_q;
	logic               tail_hit_q;
	logic               tail_done_q;
	logic [ID_BITS-1:0] tail_id_q;
	logic               out_v_q;
	logic [ID_BITS-1:0] out_id_q;
	logic               out_found_q;
	logic               out_full_q;
	logic               out_ovf_q;

	logic [31:0]        given_w;
	logic [ID_BITS-1:0] g_sat;
	logic               out_free;
	logic               take;
	logic               is_tab;
	logic               emit;
	logic [ID_BITS-1:0] res;
	logic               found;
	logic               full;
	logic               ovf;
	logic [ID_BITS-1:0] nxt_conn;
	logic [ID_BITS-1:0] nxt_node;

	assign given_w  = {16'b0, req.given_id};
	assign g_sat    = (given_w > 32'(ID_MAX)) ? ID_MAX : ID_BITS'(given_w);
	assign out_free = !out_v_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && out_free;
	assign take     = req.valid && req.ready;
	assign is_tab   = req.kind inside {KIND_SEED_CONN, KIND_CONN_ID, KIND_SPLIT_ID};

	always_comb begin
		nxt_conn = conn_ctr_q;
		nxt_node = node_ctr_q;
		res      = '0;
		found    = 1'b0;
		full     = 1'b0;
		ovf      = 1'b0;
		emit     = 1'b0;
		if (take && !is_tab) begin
			emit = 1'b1;
			case (req.kind)
				KIND_CLEAR: begin
					nxt_conn = '0;
					nxt_node = '0;
				end
				KIND_SEED_NODE: begin
					if (g_sat >= node_ctr_q) begin
						if (g_sat == ID_MAX) begin
							nxt_node = ID_MAX;
							ovf      = 1'b1;
						end else begin
							nxt_node = g_sat + 1'b1;
						end
					end
				end
				KIND_FRESH_NODE: begin
					res = node_ctr_q;
					if (node_ctr_q == ID_MAX) begin
						ovf = 1'b1;
					end else begin
						nxt_node = node_ctr_q + 1'b1;
					end
				end
				default: ;
			endcase
		end else if (state_q == ST_FINISH && out_free) begin
			emit  = 1'b1;
			found = tail_hit_q;
			case (kind_q)
				KIND_SEED_CONN: begin
					full = !tail_done_q;
					if (g_q >= conn_ctr_q) begin
						if (g_q == ID_MAX) begin
							nxt_conn = ID_MAX;
							ovf      = 1'b1;
						end else begin
							nxt_conn = g_q + 1'b1;
						end
					end
				end
				KIND_CONN_ID: begin
					if (tail_hit_q) begin
						res = tail_id_q;
					end else begin
						res  = conn_ctr_q;
						full = !tail_done_q;
						if (conn_ctr_q == ID_MAX) begin
							ovf = 1'b1;
						end else begin
							nxt_conn = conn_ctr_q + 1'b1;
						end
					end
				end
				KIND_SPLIT_ID: begin
					if (tail_hit_q) begin
						res = tail_id_q;
					end else begin
						res  = node_ctr_q;
						full = !tail_done_q;
						if (node_ctr_q == ID_MAX) begin
							ovf = 1'b1;
						end else begin
							nxt_node = node_ctr_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= '0;
			key_q       <= '0;
			g_q         <= '0;
			wr_id_q     <= '0;
			split_q     <= 1'b0;
			seed_q      <= 1'b0;
			clr_q       <= 1'b0;
			launch_q    <= 1'b0;
			conn_ctr_q  <= '0;
			node_ctr_q  <= '0;
			tail_hit_q  <= 1'b0;
			tail_done_q <= 1'b0;
			tail_id_q   <= '0;
			out_v_q     <= 1'b0;
			out_id_q    <= '0;
			out_found_q <= 1'b0;
			out_full_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			clr_q    <= 1'b0;
			launch_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						kind_q   <= req.kind;
						key_q    <= {req.from_node, req.to_node};
						g_q      <= g_sat;
						split_q  <= (req.kind == KIND_SPLIT_ID);
						seed_q   <= (req.kind == KIND_SEED_CONN);
						clr_q    <= (req.kind == KIND_CLEAR);
						launch_q <= is_tab;
						// A miss stores the value the counter would issue now; seeds store the given id
						if (req.kind == KIND_SEED_CONN) begin
							wr_id_q <= g_sat;
						end else if (req.kind == KIND_SPLIT_ID) begin
							wr_id_q <= node_ctr_q;
						end else begin
							wr_id_q <= conn_ctr_q;
						end
						if (is_tab) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (tail.live) begin
						tail_hit_q  <= tail.hit;
						tail_done_q <= tail.done;
						tail_id_q   <= tail_id;
						state_q     <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			conn_ctr_q <= nxt_conn;
			node_ctr_q <= nxt_node;
			if (emit) begin
				out_v_q     <= 1'b1;
				out_id_q    <= res;
				out_found_q <= found;
				out_full_q  <= full;
				out_ovf_q   <= ovf;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign bc     = '{clr: clr_q, split: split_q, seed: seed_q, key: key_q};
	assign wr_id  = wr_id_q;
	assign launch = '{live: launch_q, done: 1'b0, hit: 1'b0};

	assign rsp.valid            = out_v_q;
	assign rsp.result_id        = RES_W'(out_id_q);
	assign rsp.was_found        = out_found_q;
	assign rsp.table_full       = out_full_q;
	assign rsp.counter_overflow = out_ovf_q;

	`PIDIT_ASSERT(a_tail_in_scan, clk, arst_n, !tail.live || state_q == ST_SCAN, "token left the row outside a search")
	`PIDIT_ASSERT_NEXT(a_launch_single, clk, arst_n, launch_q, !launch_q, "search token launched twice")
	`PIDIT_ASSERT_NEXT(a_finish_emits, clk, arst_n, state_q == ST_FINISH && out_free, out_v_q && state_q == ST_IDLE, "finished search gave no result")

endmodule

/* rtl/pair_id_intern_table_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pair_id_intern_table_unit
// Interns (from_node, to_node) pairs into stable connection numbers and
// split-node ids. Each of TABLE_DEPTH cells holds one connection entry and
// one split entry; entries fill from the front and are only emptied together
// by a clear request. Clear, seed-node, fresh-node and unused-kind requests
// need no search and load the result register on acceptance. Connection
// lookups, split lookups and connection seeds send a search token along
// the cell row, one cell per clock; from the token leaving the row the
// counter update and result are formed once the result register is free.
// One request is in flight; the next needs a free result register.
// ---------------------------------------------------------------------------
module pair_id_intern_table_unit #(
	parameter int TABLE_DEPTH = 256,
	parameter int ID_BITS     = 16
) (
	input logic         clk,
	input logic         arst_n,
	pidit_req_if.sink   req,
	pidit_rsp_if.source rsp
);
	import pidit_pkg::*;

	bcast_t             bc;
	logic [ID_BITS-1:0] wr_id;
	tok_t               tok [TABLE_DEPTH+1];
	logic [ID_BITS-1:0] tid [TABLE_DEPTH+1];

	pidit_ctrl #(
		.ID_BITS(ID_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.bc      (bc),
		.wr_id   (wr_id),
		.launch  (tok[0]),
		.tail    (tok[TABLE_DEPTH]),
		.tail_id (tid[TABLE_DEPTH])
	);

	// Carried id is only meaningful once a cell has hit
	assign tid[0] = wr_id;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		pidit_cell #(
			.ID_BITS(ID_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bc      (bc),
			.wr_id   (wr_id),
			.tin     (tok[i]),
			.tin_id  (tid[i]),
			.tout    (tok[i+1]),
			.tout_id (tid[i+1])
		);
	end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for pair_id_intern_table_unit. A short table of
// directed requests covers the field extremes, every request kind, counter
// saturation and the unused kind codes. Random traffic follows: mixed
// requests on a small pool of pairs so that lookups hit, plus long runs of
// fresh pairs that fill each table. Results are checked in order: against a
// behavioural copy of both tables and both counters, or the directed want.
// ---------------------------------------------------------------------------
module tb_top;
	import pidit_pkg::*;

	localparam int          DEPTH       = 256;
	localparam int unsigned ID_MAX      = 32'd65535;
	localparam int          NUM_DIR     = 25;
	localparam int          RAND_ITEMS  = 1700;
	localparam int          POOL_N      = 24;
	localparam int          FILL_LEN    = 290;
	localparam int          HOLD_CYCLES = 700;
	localparam int          STALL_LIMIT = 5000;
	localparam int          CONN_SIDE   = 0;
	// the split side is served by the node counter
	localparam int          SPLIT_SIDE  = 1;

	localparam logic [KIND_W-1:0] KIND_RSVD_6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RSVD_7 = 3'd7;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [NODE_W-1:0] from_node;
		logic [NODE_W-1:0] to_node;
		logic [NODE_W-1:0] given_id;
	} pair_req_t;

	typedef struct packed {
		logic [RES_W-1:0] result_id;
		logic             was_found;
		logic             table_full;
		logic             counter_overflow;
	} id_answer_t;

	typedef struct packed {
		pair_req_t  rq;
		logic       typed;
		id_answer_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	pidit_req_if req ();
	pidit_rsp_if rsp ();

	pair_id_intern_table_unit #(
		.TABLE_DEPTH(DEPTH),
		.ID_BITS    (16)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// Shadow of both tables and counters
	logic [KEY_W-1:0] pair_keys [2][DEPTH];
	logic [RES_W-1:0] pair_ids  [2][DEPTH];
	bit               pair_live [2][DEPTH];
	int unsigned      next_id   [2];

	id_answer_t       ids_due [$];
	logic [KEY_W-1:0] key_pool [POOL_N];
	int               sent_cnt;
	int               got_cnt;
	int               mismatch_cnt;

	dir_row_t dir_rows [NUM_DIR] = '{
		'{'{KIND_CLEAR,      16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
		'{'{KIND_CONN_ID,    16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
		'{'{KIND_CONN_ID,    16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0}},
		'{'{KIND_CONN_ID,    16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{16'h0001, 1'b0, 1'b0, 1'b0}},
		'{'{KIND_SPLIT_ID,   16'hFFFF, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
		'{'{KIND_FRESH_NODE, 16'h1234, 16'h4321, 16'hFFFF}, 1'b1, '{16'h0001, 1'b0, 1'b0, 1'b0}},
		'{'{KIND_SPLIT_ID,   16'hFFFF, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0}},
		'{'{KIND_SEED_CONN,  16'h0000, 16'hFFFF, 16'h0064}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
		'{'{KIND_CONN_ID,    16'h0000, 16'hFFFF, 16'h0000}, 1'b1, '{16'h0064, 1'b1, 1'b0, 1'b0}},
		'{'{KIND_CONN_ID,    16'h1234, 16'h5678, 16'h0000}, 1'b0, '0},
		'{'{KIND_SEED_CONN,  16'h0000, 16'h0000, 16'h0005}, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b0}},
		'{'{KIND_CONN_ID,    16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'h0005, 1'b1, 1'b0, 1'b0}},
		'{'{KIND_SEED_NODE,  16'h0000, 16'h0000, 16'hFFFE}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
		'{'{KIND_FRESH_NODE, 16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'hFFFF, 1'b0, 1'b0, 1'b1}},
		'{'{KIND_SPLIT_ID,   16'hAAAA, 16'h5555, 16'h0000}, 1'b1, '{16'hFFFF, 1'b0, 1'b0, 1'b1}},
		'{'{KIND_SPLIT_ID,   16'hAAAA, 16'h5555, 16'h0000}, 1'b1, '{16'hFFFF, 1'b1, 1'b0, 1'b0}},
		'{'{KIND_SEED_CONN,  16'h5555, 16'hAAAA, 16'hFFFF}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b1}},
		'{'{KIND_CONN_ID,    16'h0001, 16'h0001, 16'h0000}, 1'b1, '{16'hFFFF, 1'b0, 1'b0, 1'b1}},
		'{'{KIND_SEED_NODE,  16'h0000, 16'h0000, 16'hFFFF}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b1}},
		'{'{KIND_RSVD_6,     16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
		'{'{KIND_RSVD_7,     16'h8000, 16'h0001, 16'hFFFF}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
		'{'{KIND_SEED_NODE,  16'h0000, 16'h0000, 16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
		'{'{KIND_CLEAR,      16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
		'{'{KIND_CONN_ID,    16'h0000, 16'hFFFF, 16'h0000}, 1'b1, '{16'h0000, 1'b0, 1'b0, 1'b0}},
		'{'{KIND_SPLIT_ID,   16'h1234, 16'h5678, 16'h0000}, 1'b0, '0}
	};

	function automatic int find_pair(int side, logic [KEY_W-1:0] key);
		for (int i = 0; i < DEPTH; i++) begin
			if (pair_live[side][i] && pair_keys[side][i] == key)
				return i;
		end
		return -1;
	endfunction

	// Take the lowest free entry; report whether one was free
	function automatic bit store_pair(int side, logic [KEY_W-1:0] key, logic [RES_W-1:0] id);
		for (int i = 0; i < DEPTH; i++) begin
			if (!pair_live[side][i]) begin
				pair_live[side][i] = 1'b1;
				pair_keys[side][i] = key;
				pair_ids[side][i]  = id;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic [RES_W-1:0] take_id(int side, output bit ovf);
		logic [RES_W-1:0] v;
		ovf = 1'b0;
		if (next_id[side] >= ID_MAX) begin
			ovf = 1'b1;
			next_id[side] = ID_MAX;
			return RES_W'(ID_MAX);
		end
		v = RES_W'(next_id[side]);
		next_id[side] = next_id[side] + 1;
		return v;
	endfunction

	// Raise the counter past a seeded id, saturating at the top
	function automatic bit raise_ctr(int side, logic [NODE_W-1:0] g);
		if (int'(g) >= next_id[side]) begin
			if (int'(g) >= ID_MAX) begin
				next_id[side] = ID_MAX;
				return 1'b1;
			end
			next_id[side] = int'(g) + 1;
		end
		return 1'b0;
	endfunction

	function automatic id_answer_t lookup_or_issue(int side, logic [KEY_W-1:0] key);
		id_answer_t a;
		int         idx;
		bit         ovf;
		a   = '0;
		idx = find_pair(side, key);
		if (idx >= 0) begin
			a.was_found = 1'b1;
			a.result_id = pair_ids[side][idx];
		end else begin
			a.result_id        = take_id(side, ovf);
			a.counter_overflow = ovf;
			if (!store_pair(side, key, a.result_id))
				a.table_full = 1'b1;
		end
		return a;
	endfunction

	function automatic id_answer_t predict_ids(pair_req_t r);
		id_answer_t       a;
		logic [KEY_W-1:0] key;
		int               idx;
		bit               ovf;
		a   = '0;
		key = {r.from_node, r.to_node};
		case (r.kind)
			KIND_CLEAR: begin
				for (int s = 0; s < 2; s++) begin
					next_id[s] = 0;
					for (int i = 0; i < DEPTH; i++)
						pair_live[s][i] = 1'b0;
				end
			end
			KIND_SEED_CONN: begin
				idx = find_pair(CONN_SIDE, key);
				if (idx >= 0) begin
					a.was_found = 1'b1;
					pair_ids[CONN_SIDE][idx] = r.given_id;
				end else if (!store_pair(CONN_SIDE, key, r.given_id)) begin
					a.table_full = 1'b1;
				end
				a.counter_overflow = raise_ctr(CONN_SIDE, r.given_id);
			end
			KIND_SEED_NODE: a.counter_overflow = raise_ctr(SPLIT_SIDE, r.given_id);
			KIND_CONN_ID:   a = lookup_or_issue(CONN_SIDE, key);
			KIND_FRESH_NODE: begin
				a.result_id        = take_id(SPLIT_SIDE, ovf);
				a.counter_overflow = ovf;
			end
			KIND_SPLIT_ID:  a = lookup_or_issue(SPLIT_SIDE, key);
			default: ;
		endcase
		return a;
	endfunction

	function automatic pair_req_t draw_mixed();
		pair_req_t        r;
		logic [KEY_W-1:0] key;
		int               p;
		int               q;
		p = $urandom_range(99);
		q = $urandom_range(99);
		if ($urandom_range(99) < 70)
			key = key_pool[$urandom_range(POOL_N - 1)];
		else
			key = $urandom();
		{r.from_node, r.to_node} = key;
		if (p < 2)
			r.kind = KIND_CLEAR;
		else if (p < 4)
			r.kind = $urandom_range(1) ? KIND_RSVD_7 : KIND_RSVD_6;
		else if (p < 14)
			r.kind = KIND_SEED_CONN;
		else if (p < 22)
			r.kind = KIND_SEED_NODE;
		else if (p < 32)
			r.kind = KIND_FRESH_NODE;
		else if (p < 60)
			r.kind = KIND_SPLIT_ID;
		else
			r.kind = KIND_CONN_ID;
		if (q < 4)
			r.given_id = 16'hFFFF;
		else if (q < 8)
			r.given_id = 16'hFFFE;
		else if (q < 50)
			r.given_id = NODE_W'($urandom_range(700));
		else
			r.given_id = NODE_W'($urandom());
		return r;
	endfunction

	// Fresh pairs against one table, to drive it past full
	function automatic pair_req_t draw_fill(int side);
		pair_req_t        r;
		logic [KEY_W-1:0] key;
		if ($urandom_range(99) < 10)
			key = key_pool[$urandom_range(POOL_N - 1)];
		else
			key = $urandom();
		{r.from_node, r.to_node} = key;
		r.kind     = (side == CONN_SIDE) ? KIND_CONN_ID : KIND_SPLIT_ID;
		r.given_id = NODE_W'($urandom());
		return r;
	endfunction

	task automatic offer_req(input pair_req_t r, input bit typed, input id_answer_t want);
		id_answer_t guess;
		if (!(sent_cnt >= 600 && sent_cnt < 900) && $urandom_range(99) < 21) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req.valid     <= 1'b1;
		req.kind      <= r.kind;
		req.from_node <= r.from_node;
		req.to_node   <= r.to_node;
		req.given_id  <= r.given_id;
		do
			@(posedge clk);
		while (!req.ready);
		guess = predict_ids(r);
		ids_due.push_back(typed ? want : guess);
		sent_cnt++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin : drive_requests
		int seg;
		int len;
		int first_rand;
		req.valid     <= 1'b0;
		req.kind      <= KIND_CLEAR;
		req.from_node <= '0;
		req.to_node   <= '0;
		req.given_id  <= '0;
		sent_cnt     = 0;
		mismatch_cnt = 0;
		for (int i = 0; i < POOL_N; i++)
			key_pool[i] = $urandom();
		wait (arst_n === 1'b1);
		@(posedge clk);

		for (int i = 0; i < NUM_DIR; i++)
			offer_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);

		first_rand = sent_cnt;
		seg        = 0;
		while (sent_cnt - first_rand < RAND_ITEMS) begin
			if (seg == 3 || seg == 9) begin
				for (int i = 0; i < FILL_LEN; i++)
					offer_req(draw_fill(seg == 3 ? CONN_SIDE : SPLIT_SIDE), 1'b0, '0);
			end else begin
				len = $urandom_range(30, 60);
				for (int i = 0; i < len; i++)
					offer_req(draw_mixed(), 1'b0, '0);
			end
			seg++;
		end
		req.valid <= 1'b0;

		while (ids_due.size() != 0)
			@(posedge clk);
		// catch any stray result after the last one
		repeat (DEPTH + 8) @(posedge clk);
		if (ids_due.size() != 0 || mismatch_cnt != 0)
			$display("RESULT: ERROR");
		else
			$display("RESULT: OK");
		$finish;
	end

	initial begin : take_results
		int         hold_left;
		bit         held;
		id_answer_t seen;
		id_answer_t due;
		hold_left = 0;
		held      = 1'b0;
		got_cnt   = 0;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				seen = '{rsp.result_id, rsp.was_found, rsp.table_full, rsp.counter_overflow};
				if (ids_due.size() == 0) begin
					mismatch_cnt++;
					$display("%0t: result with nothing expected, actual id=%h found=%b full=%b ovf=%b",
						$time, seen.result_id, seen.was_found, seen.table_full,
						seen.counter_overflow);
				end else begin
					due = ids_due.pop_front();
					if (seen.result_id !== due.result_id || seen.was_found !== due.was_found ||
							seen.table_full !== due.table_full ||
							seen.counter_overflow !== due.counter_overflow) begin
						mismatch_cnt++;
						$display("%0t: mismatch expected id=%h found=%b full=%b ovf=%b, actual id=%h found=%b full=%b ovf=%b",
							$time, due.result_id, due.was_found, due.table_full,
							due.counter_overflow, seen.result_id, seen.was_found,
							seen.table_full, seen.counter_overflow);
					end
				end
				got_cnt++;
			end
			// hold off once for a long stretch so that requests back up
			if (got_cnt == 150 && !held) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= (got_cnt >= 600 && got_cnt < 900) || ($urandom_range(99) >= 21);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
